/* hw/rtl/sha256_pkg.sv */
// Package: SHA-256 constants, round table and a rotate helper function.
`timescale 1ns / 1ps
package sha256_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds = 64;

	typedef logic [WordW-1:0] word_t;
	typedef logic [5:0] round_idx_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load_byte;   // write a byte into the block window
		logic [7:0] load_value;
		logic       zero_fill;   // write a zero byte at the fill position
		logic       put_len;     // overwrite last two words with the bit length
		logic       start;       // start compression of the current block
		logic       reset_hash;  // return chaining and length to initial state
		logic       count_bits;  // add eight to the bit length
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic       busy;        // compression rounds running
		logic [5:0] fill;        // bytes held in the block window
	} dp_stat_t;

	localparam word_t H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

endpackage

/* hw/rtl/sha256_if.sv */
// Interfaces: valid/ready channels for message bytes and digest words.
`timescale 1ns / 1ps
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last_item;
	modport source (output valid, data_byte, byte_valid, last_item, input ready);
	modport sink (input valid, data_byte, byte_valid, last_item, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        final_word;
	modport source (output valid, digest_word, word_number, final_word, input ready);
	modport sink (input valid, digest_word, word_number, final_word, output ready);
endinterface

/* hw/rtl/sha256_dp.sv */
// Datapath: block window, message schedule, round unit, chaining words.
`timescale 1ns / 1ps
module sha256_dp
	import sha256_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	input  logic [2:0] rd_sel,
	output word_t    rd_word
);

	// sixteen-word sliding schedule window, doubles as the byte buffer
	word_t      w_q [BlockWords];
	word_t      h_q [8];
	word_t      v_q [8];
	logic [63:0] bits_q;
	logic [5:0] fill_q;
	logic       busy_q;
	round_idx_t rnd_q;

	word_t s0, s1, w_next, t1, t2, e, a;
	logic [7:0] wr_byte;
	logic       wr_en;

	assign stat.busy = busy_q;
	assign stat.fill = fill_q;
	assign rd_word = h_q[rd_sel];

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_next = w_q[0] + s0 + w_q[9] + s1;
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
			((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[rnd_q] + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
			((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
		wr_en = cmd.load_byte | cmd.zero_fill;
		wr_byte = cmd.load_byte ? cmd.load_value : 8'h00;
	end

	// load bytes and the bit length into the byte buffer, and run the schedule shift during rounds
	always_ff @(posedge clk) begin
		if (busy_q) begin
			for (int i = 0; i < BlockWords - 1; i++) w_q[i] <= w_q[i+1];
			w_q[BlockWords-1] <= w_next;
		end else if (cmd.put_len) begin
			w_q[14] <= bits_q[63:32];
			w_q[15] <= bits_q[31:0];
		end else if (wr_en) begin
			case (fill_q[1:0])
				2'd0: w_q[fill_q[5:2]][31:24] <= wr_byte;
				2'd1: w_q[fill_q[5:2]][23:16] <= wr_byte;
				2'd2: w_q[fill_q[5:2]][15:8] <= wr_byte;
				default: w_q[fill_q[5:2]][7:0] <= wr_byte;
			endcase
		end
	end

	// advance fill pointer, bit length, round counter, working and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			busy_q <= 1'b0;
			rnd_q <= '0;
			bits_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
		end else begin
			if (wr_en) fill_q <= fill_q + 6'd1;
			if (cmd.count_bits) bits_q <= bits_q + 64'd8;
			if (cmd.start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
				fill_q <= '0;
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end else if (busy_q) begin
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
				// stop on the last round and keep its index for the fold
				if (rnd_q == 6'(Rounds - 1)) busy_q <= 1'b0;
				else rnd_q <= rnd_q + 6'd1;
			end else if (rnd_q == 6'(Rounds - 1)) begin
				// fold working words into chaining words once
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				rnd_q <= '0;
			end
			if (cmd.reset_hash) begin
				for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
				bits_q <= '0;
			end
		end
	end

endmodule

/* hw/rtl/sha256_ctrl.sv */
// Controller: sequences byte loads, padding, compression and digest output.
`timescale 1ns / 1ps
module sha256_ctrl
	import sha256_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sha256_in_if.sink   in_ch,
	sha256_out_if.source out_ch,
	output dp_cmd_t   cmd,
	input  dp_stat_t  stat,
	output logic [2:0] rd_sel,
	input  word_t     rd_word
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_COMP = 4'd1;
	localparam logic [3:0] S_PAD = 4'd2;
	localparam logic [3:0] S_ZERO = 4'd3;
	localparam logic [3:0] S_ZCOMP = 4'd4;
	localparam logic [3:0] S_LEN = 4'd5;
	localparam logic [3:0] S_FCOMP = 4'd6;
	localparam logic [3:0] S_FOLD = 4'd7;
	localparam logic [3:0] S_EMIT = 4'd8;
	localparam logic [3:0] S_WAIT = 4'd9;

	logic [3:0] state_q, state_d;
	logic       last_q, last_d;
	logic [2:0] idx_q, idx_d;
	logic       ovalid_q, ovalid_d;
	word_t      oword_q;
	logic [2:0] onum_q;
	logic       accept;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept = in_ch.valid & in_ch.ready;
	assign out_ch.valid = ovalid_q;
	assign out_ch.digest_word = oword_q;
	assign out_ch.word_number = onum_q;
	assign out_ch.final_word = (onum_q == 3'd7);
	assign rd_sel = idx_q;

	// decode next state and datapath commands
	always_comb begin
		state_d = state_q;
		last_d = last_q;
		idx_d = idx_q;
		ovalid_d = ovalid_q;
		cmd = '0;
		cmd.load_value = in_ch.data_byte;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					last_d = in_ch.last_item;
					if (in_ch.byte_valid) begin
						cmd.load_byte = 1'b1;
						cmd.count_bits = 1'b1;
					end
					if (in_ch.byte_valid && stat.fill == 6'd63) state_d = S_COMP;
					else if (in_ch.last_item) state_d = S_PAD;
				end
			end
			S_COMP: begin
				cmd.start = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (!stat.busy) state_d = last_q ? S_PAD : S_IDLE;
			end
			S_PAD: begin
				cmd.load_byte = 1'b1;
				cmd.load_value = PAD_BYTE;
				state_d = (stat.fill >= LEN_POS) ? S_ZERO : S_LEN;
			end
			S_ZERO: begin
				if (stat.fill == 6'd0) begin
					state_d = S_ZCOMP;
				end else begin
					cmd.zero_fill = 1'b1;
					if (stat.fill == 6'd63) state_d = S_ZCOMP;
				end
			end
			S_ZCOMP: begin
				if (stat.fill == 6'd0 && !stat.busy) begin
					cmd.start = 1'b1;
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				if (!stat.busy) begin
					if (stat.fill == LEN_POS) begin
						cmd.put_len = 1'b1;
						state_d = S_FCOMP;
					end else begin
						cmd.zero_fill = 1'b1;
					end
				end
			end
			S_FCOMP: begin
				cmd.start = 1'b1;
				state_d = S_FOLD;
			end
			S_FOLD: begin
				if (!stat.busy) begin
					state_d = S_EMIT;
					idx_d = 3'd0;
				end
			end
			S_EMIT: begin
				if (!ovalid_q || out_ch.ready) begin
					ovalid_d = 1'b1;
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.reset_hash = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (ovalid_q && out_ch.ready && !(state_q == S_EMIT)) ovalid_d = 1'b0;
	end

	// hold state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= 1'b0;
			idx_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q <= last_d;
			idx_q <= idx_d;
			ovalid_q <= ovalid_d;
		end
	end

	// load output payload on each emitted word
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && (!ovalid_q || out_ch.ready)) begin
			oword_q <= rd_word;
			onum_q <= idx_q;
		end
	end

endmodule

/* hw/rtl/sha256_byte_stream_hasher_top.sv */
// Top level: SHA-256 hasher over a byte stream.
// At most one byte is taken per request, and only when the block is idle;
// every 64th byte starts a compression of the block (a start step, 64 rounds
// at one round per cycle, then a fold into the chaining words), and no request
// is taken until it ends. A last request pads, runs one or two more
// compressions plus the zero-fill sweep over the rest of the block window,
// then presents the eight digest words in order through a one-entry output
// register; the input stays blocked until the seventh word is taken and is
// open again while the eighth word waits. The chaining state then returns to
// the initial hash values for the next message.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_top
	import sha256_pkg::*;
(
	input logic clk,
	input logic arst_n,
	sha256_in_if.sink   in_ch,
	sha256_out_if.source out_ch
);

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [2:0] rd_sel;
	word_t      rd_word;

	sha256_ctrl u_ctrl (
		.clk, .arst_n, .in_ch, .out_ch, .cmd, .stat, .rd_sel, .rd_word
	);

	sha256_dp u_dp (
		.clk, .arst_n, .cmd, .stat, .rd_sel, .rd_word
	);

endmodule

/* hw/rtl/sha256_checker.sv */
// Checker: port-level properties of the hasher, bound to the top level.
`timescale 1ns / 1ps
module sha256_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] word_number,
	input logic       final_word
);

	// final flag marks word seven only
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (final_word == (word_number == 3'd7)))
		else $error("final_word mismatch");

	// words come in order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && word_number != 3'd7) |=>
		(!out_valid || word_number == $past(word_number) + 3'd1))
		else $error("digest words out of order");

	// no input taken while a digest word other than the final one is presented
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !final_word) |-> !in_ready)
		else $error("input accepted mid-digest");

	// stalled output stays valid and keeps its word number
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(word_number)))
		else $error("stalled result changed");

endmodule

bind sha256_byte_stream_hasher_top sha256_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.word_number(out_ch.word_number), .final_word(out_ch.final_word)
);

/* bench/testbench.sv */
// Testbench for the byte-stream SHA-256 hasher: directed and random messages checked per word.
`timescale 1ns / 1ps
module testbench;
	import sha256_pkg::*;

	// One message byte request
	typedef struct {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last_item;
	} byte_req_t;

	// One digest word
	typedef struct {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        final_word;
	} digest_out_t;

	// Directed row: request plus optional typed-in word 0
	typedef struct {
		byte_req_t   req;
		logic        known;
		logic [31:0] word0;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sha256_in_if  in_ch();
	sha256_out_if out_ch();

	sha256_byte_stream_hasher_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #5 clk = ~clk;

	// Hasher shadow state
	logic [31:0] chain_h [8];
	logic [63:0] length_bits;
	logic [7:0]  blk [64];
	int          blk_fill;

	digest_out_t expected_words [$];
	logic [31:0] known_word0 [$];
	logic        known_flag [$];

	byte_req_t pending_reqs [$];
	int        sender_idle_pct;
	int        receiver_idle_pct;
	int        error_count;
	bit        stim_done;

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Run one compression over the shadow block
	task automatic compress_shadow();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain_h[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_h[i] = chain_h[i] + v[i];
	endtask

	task automatic clear_shadow();
		for (int i = 0; i < 8; i++)
			chain_h[i] = H_INIT[i];
		length_bits = '0;
		blk_fill = 0;
	endtask

	// Advance the shadow hasher by one accepted request
	task automatic hash_request(byte_req_t r);
		digest_out_t d;
		if (r.byte_valid) begin
			blk[blk_fill] = r.data_byte;
			blk_fill++;
			length_bits += 64'd8;
			if (blk_fill == 64) begin
				compress_shadow();
				blk_fill = 0;
			end
		end
		if (r.last_item) begin
			blk[blk_fill] = PAD_BYTE;
			blk_fill++;
			if (blk_fill > LEN_POS) begin
				for (int i = blk_fill; i < 64; i++)
					blk[i] = 8'h00;
				compress_shadow();
				blk_fill = 0;
			end
			for (int i = blk_fill; i < LEN_POS; i++)
				blk[i] = 8'h00;
			for (int i = 0; i < 8; i++)
				blk[63-i] = length_bits[8*i +: 8];
			compress_shadow();
			for (int i = 0; i < 8; i++) begin
				d.digest_word = chain_h[i];
				d.word_number = 3'(i);
				d.final_word = (i == 7);
				expected_words.push_back(d);
			end
			clear_shadow();
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic byte_req_t mk(logic [7:0] b, logic v, logic l);
		byte_req_t r;
		r.data_byte = b; r.byte_valid = v; r.last_item = l;
		return r;
	endfunction

	// Queue a message of n random bytes, with occasional byte-less requests mixed in, ending with a last flag
	task automatic queue_message(int n, bit empty_tail);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				pending_reqs.push_back(mk(8'($urandom), 1'b0, 1'b0));
			pending_reqs.push_back(mk(8'($urandom), 1'b1,
				(i == n - 1) && !empty_tail));
		end
		if (empty_tail || n == 0)
			pending_reqs.push_back(mk(8'($urandom), 1'b0, 1'b1));
	endtask

	// Drive requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= '0;
			in_ch.byte_valid <= 1'b0;
			in_ch.last_item <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				hash_request(pending_reqs.pop_front());
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_reqs.size() > 0 &&
				    $urandom_range(0, 99) >= sender_idle_pct) begin
					in_ch.valid <= 1'b1;
					in_ch.data_byte <= pending_reqs[0].data_byte;
					in_ch.byte_valid <= pending_reqs[0].byte_valid;
					in_ch.last_item <= pending_reqs[0].last_item;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Check digest words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", out_ch.digest_word, 32'h0);
				end else begin
					digest_out_t e;
					e = expected_words.pop_front();
					if (out_ch.digest_word !== e.digest_word)
						report_mismatch("digest_word", out_ch.digest_word, e.digest_word);
					if (out_ch.word_number !== e.word_number)
						report_mismatch("word_number", 32'(out_ch.word_number),
							32'(e.word_number));
					if (out_ch.final_word !== e.final_word)
						report_mismatch("final_word", 32'(out_ch.final_word),
							32'(e.final_word));
					if (e.word_number == 3'd0 && known_flag.size() > 0) begin
						if (known_flag.pop_front() &&
						    out_ch.digest_word !== known_word0[0])
							report_mismatch("known word0", out_ch.digest_word,
								known_word0[0]);
						void'(known_word0.pop_front());
					end
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	task automatic drain_requests();
		while (pending_reqs.size() > 0 || in_ch.valid)
			@(posedge clk);
	endtask

	// Directed table: empty message, "abc", single-byte extremes, a byte closed by an empty final request
	stim_row_t dir_rows [$];

	initial begin
		stim_row_t row;
		error_count = 0;
		stim_done = 0;
		sender_idle_pct = 34;
		receiver_idle_pct = 57;
		clear_shadow();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message via an empty final request
		row.req = mk(8'h00, 1'b0, 1'b1); row.known = 1; row.word0 = 32'he3b0c442;
		dir_rows.push_back(row);
		// Ignored request, then "abc"
		row.req = mk(8'hff, 1'b0, 1'b0); row.known = 0; dir_rows.push_back(row);
		row.req = mk(8'h61, 1'b1, 1'b0); dir_rows.push_back(row);
		row.req = mk(8'h62, 1'b1, 1'b0); dir_rows.push_back(row);
		row.req = mk(8'h63, 1'b1, 1'b1); row.known = 1; row.word0 = 32'hba7816bf;
		dir_rows.push_back(row);
		// Single byte extremes
		row.req = mk(8'h00, 1'b1, 1'b1); row.known = 0; dir_rows.push_back(row);
		row.req = mk(8'hff, 1'b1, 1'b1); dir_rows.push_back(row);
		row.req = mk(8'h55, 1'b1, 1'b0); dir_rows.push_back(row);
		row.req = mk(8'haa, 1'b0, 1'b1); dir_rows.push_back(row);

		foreach (dir_rows[i]) begin
			pending_reqs.push_back(dir_rows[i].req);
			if (dir_rows[i].req.last_item) begin
				known_flag.push_back(dir_rows[i].known);
				known_word0.push_back(dir_rows[i].word0);
			end
		end
		drain_requests();

		// Padding boundaries: 55, 56 and 64 bytes
		queue_message(55, 0);
		queue_message(56, 0);
		queue_message(64, 1);
		drain_requests();

		// Random messages across three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				sender_idle_pct = 57; receiver_idle_pct = 34;
			end else if (phase == 2) begin
				sender_idle_pct = 0; receiver_idle_pct = 0;
			end
			for (int m = 0; m < 3; m++) begin
				int n;
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 70)
					: $urandom_range(0, 12);
				queue_message(n, $urandom_range(0, 3) == 0);
			end
			drain_requests();
		end
		stim_done = 1;

		// Wait out the last digests
		fork
			while (expected_words.size() > 0) @(posedge clk);
			repeat (20000) @(posedge clk);
		join_any
		disable fork;
		repeat (300) @(posedge clk);
		if (error_count == 0 && expected_words.size() == 0)
			$display("sha256_byte_stream_hasher_top: match");
		else
			$display("sha256_byte_stream_hasher_top: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("sha256_byte_stream_hasher_top: mismatch");
		$finish;
	end
endmodule

/* files.f */
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_if.sv
hw/rtl/sha256_dp.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_byte_stream_hasher_top.sv
hw/rtl/sha256_checker.sv
bench/testbench.sv
